// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the decoder's sequencer (dmrd_seq.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, held off during reset.
`define DMRD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, held off during reset.
`define DMRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dmrd_pkg.sv =====
// Types and constants of the delta-modulation row decoder.
package dmrd_pkg;

    localparam int STEP_W  = 12;
    localparam int WIDTH_W = 13;
    localparam int PIX_W   = 8;
    localparam int COL_W   = 12;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [STEP_W-1:0]  STEP_RST  = 12'd16;
    localparam logic [WIDTH_W-1:0] WIDTH_RST = 13'd512;

    // register index codes, taken from paddr[2]
    localparam logic REG_STEP  = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    typedef struct packed {
        logic [STEP_W-1:0]  step_size;
        logic [WIDTH_W-1:0] row_width;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

endpackage

// ===== rtl/core/delta_modulation_row_decoder.sv =====
// Delta-modulation row decoder top level: register file, sequencer and step unit.
//
// Input stream: one byte per beat on i_s_*. The first byte of a row is a raw
// start pixel; every later byte carries eight step bits, LSB first.
// Output stream: one pixel per beat on o_m_*; tlast marks the last pixel of
// a row, tuser the last pixel produced from an input byte.
// APB port: step_size at 0x0, row_width at 0x4; pready is tied high.
// Timing: a byte is taken in S_IDLE; the sequencer then moves to S_RUN,
// where the first pixel of the byte is registered into the output register.
// The single add-round-clamp unit produces one pixel a cycle while the
// receiver does not stall, each from the one before.
// o_s_tready is low while a byte is being worked through, so one byte is
// in flight at a time; the next byte may be taken while the last pixel
// still waits in the output register.
// When the receiver stalls, the output register holds and the sequencer
// waits with it. Reset is synchronous: registers return to step 1.0 and
// width 512, and the next byte is treated as a start pixel.
module delta_modulation_row_decoder #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] stream_byte
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [23:0]                 o_m_tdata,   // [7:0] pixel_value, [19:8] column
    output logic                        o_m_tlast,
    output logic                        o_m_tuser,   // [0] last_of_byte
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmrd_pkg::APB_AW-1:0] paddr,
    input  logic [dmrd_pkg::APB_DW-1:0] pwdata,
    output logic [dmrd_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    dmrd_pkg::t_cfg              cfg;
    logic [dmrd_pkg::PIX_W-1:0]  prev;
    logic                        up;
    logic [dmrd_pkg::PIX_W-1:0]  pix;

    dmrd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dmrd_step_unit u_step (
        .i_step (cfg.step_size),
        .i_prev (prev),
        .i_up   (up),
        .o_pix  (pix)
    );

    dmrd_seq #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .o_prev     (prev),
        .o_up       (up),
        .i_pix      (pix)
    );

endmodule

// ===== rtl/core/dmrd_regs.sv =====
// APB register file holding step size and row width.
module dmrd_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dmrd_pkg::APB_AW-1:0]       paddr,
    input  logic [dmrd_pkg::APB_DW-1:0]       pwdata,
    output logic [dmrd_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    output dmrd_pkg::t_cfg                    o_cfg
);

    dmrd_pkg::t_cfg r_cfg;
    dmrd_pkg::t_cfg n_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (paddr[2])
                dmrd_pkg::REG_STEP:  n_cfg.step_size = pwdata[dmrd_pkg::STEP_W-1:0];
                dmrd_pkg::REG_WIDTH: n_cfg.row_width = pwdata[dmrd_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            dmrd_pkg::REG_STEP:
                prdata = dmrd_pkg::APB_DW'(r_cfg.step_size);
            dmrd_pkg::REG_WIDTH:
                prdata = dmrd_pkg::APB_DW'(r_cfg.row_width);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size <= dmrd_pkg::STEP_RST;
            r_cfg.row_width <= dmrd_pkg::WIDTH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/core/dmrd_step_unit.sv =====
// Shared add, round half up and clamp unit for one delta step.
module dmrd_step_unit (
    input  logic [dmrd_pkg::STEP_W-1:0] i_step,
    input  logic [dmrd_pkg::PIX_W-1:0]  i_prev,
    input  logic                        i_up,
    output logic [dmrd_pkg::PIX_W-1:0]  o_pix
);

    logic [dmrd_pkg::STEP_W-1:0] base;
    logic [dmrd_pkg::STEP_W:0]   up_sum;
    logic [dmrd_pkg::STEP_W:0]   dn_sum;

    always_comb begin
        base   = {i_prev, 4'h0};
        up_sum = {1'b0, base} + {1'b0, i_step} + 13'd8;
        dn_sum = {1'b0, base} - {1'b0, i_step} + 13'd8;
        if (i_up) begin
            o_pix = up_sum[dmrd_pkg::STEP_W] ? 8'hFF : up_sum[11:4];
        end else if (i_step > base) begin
            o_pix = '0;
        end else begin
            o_pix = dn_sum[11:4];
        end
    end

endmodule

// ===== rtl/core/dmrd_seq.sv =====
// Bit sequencer: walks the step bits of one beat, or passes a start pixel through, and drives the output register.
`include "assert_macros.svh"

module dmrd_seq #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dmrd_pkg::t_cfg              i_cfg,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [23:0]                 o_m_tdata,
    output logic                        o_m_tlast,
    output logic                        o_m_tuser,
    output logic [dmrd_pkg::PIX_W-1:0]  o_prev,
    output logic                        o_up,
    input  logic [dmrd_pkg::PIX_W-1:0]  i_pix
);

    localparam int CW = (MAX_ROW_WIDTH > 2) ? $clog2(MAX_ROW_WIDTH) : 1;
    localparam int EW = CW + 1;
    localparam int XW = (EW > dmrd_pkg::WIDTH_W) ? EW : dmrd_pkg::WIDTH_W;

    dmrd_pkg::t_state            r_state, n_state;
    logic [7:0]                  r_byte, n_byte;
    logic [2:0]                  r_bit, n_bit;
    logic                        r_start, n_start;
    logic                        r_expect, n_expect;
    logic [dmrd_pkg::PIX_W-1:0]  r_prev, n_prev;
    logic [CW-1:0]               r_col, n_col;
    logic                        r_out_valid, n_out_valid;
    logic [dmrd_pkg::PIX_W-1:0]  r_out_pix, n_out_pix;
    logic [dmrd_pkg::COL_W-1:0]  r_out_col, n_out_col;
    logic                        r_out_done, n_out_done;
    logic                        r_out_last, n_out_last;

    logic [XW-1:0] width_x;
    logic [XW-1:0] eff_width;
    logic [XW-1:0] col_x;
    logic          done;
    logic          slot_free;
    logic          emit;
    logic          accept;

    assign o_s_tready = (r_state == dmrd_pkg::S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_out_valid || i_m_tready;
    assign emit       = (r_state == dmrd_pkg::S_RUN) && slot_free;

    assign o_prev = r_prev;
    assign o_up   = r_byte[r_bit];

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'h0, r_out_col, r_out_pix};
    assign o_m_tlast  = r_out_done;
    assign o_m_tuser  = r_out_last;

    // effective width clamped to 2..MAX_ROW_WIDTH
    always_comb begin
        width_x = XW'(i_cfg.row_width);
        col_x   = XW'(r_col);
        if (width_x < XW'(2)) begin
            eff_width = XW'(2);
        end else if (width_x > XW'(MAX_ROW_WIDTH)) begin
            eff_width = XW'(MAX_ROW_WIDTH);
        end else begin
            eff_width = width_x;
        end
        done = (col_x + XW'(1)) >= eff_width;
    end

    always_comb begin
        n_state     = r_state;
        n_byte      = r_byte;
        n_bit       = r_bit;
        n_start     = r_start;
        n_expect    = r_expect;
        n_prev      = r_prev;
        n_col       = r_col;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_pix   = r_out_pix;
        n_out_col   = r_out_col;
        n_out_done  = r_out_done;
        n_out_last  = r_out_last;

        unique case (r_state)
            dmrd_pkg::S_IDLE: begin
                if (accept) begin
                    n_byte  = i_s_tdata;
                    n_bit   = '0;
                    n_start = r_expect;
                    n_state = dmrd_pkg::S_RUN;
                end
            end
            dmrd_pkg::S_RUN: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    if (r_start) begin
                        n_out_pix  = r_byte;
                        n_out_col  = '0;
                        n_out_done = 1'b0;
                        n_out_last = 1'b1;
                        n_prev     = r_byte;
                        n_col      = CW'(1);
                        n_expect   = 1'b0;
                        n_state    = dmrd_pkg::S_IDLE;
                    end else begin
                        n_out_pix  = i_pix;
                        n_out_col  = col_x[dmrd_pkg::COL_W-1:0];
                        n_out_done = done;
                        n_out_last = done || (r_bit == 3'd7);
                        n_prev     = i_pix;
                        n_bit      = r_bit + 3'd1;
                        if (done) begin
                            n_col    = '0;
                            n_expect = 1'b1;
                        end else begin
                            n_col = r_col + CW'(1);
                        end
                        if (done || (r_bit == 3'd7)) begin
                            n_state = dmrd_pkg::S_IDLE;
                        end
                    end
                end
            end
            default: n_state = dmrd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmrd_pkg::S_IDLE;
            r_bit       <= '0;
            r_start     <= 1'b0;
            r_expect    <= 1'b1;
            r_prev      <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_start     <= n_start;
            r_expect    <= n_expect;
            r_prev      <= n_prev;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_out_pix  <= n_out_pix;
        r_out_col  <= n_out_col;
        r_out_done <= n_out_done;
        r_out_last <= n_out_last;
    end

    `DMRD_ASSERT_IMPL(a_row_end_closes_beat, o_m_tvalid && o_m_tlast, o_m_tuser,
        "row end on a pixel that is not the last of its beat")
    `DMRD_ASSERT_IMPL(a_mid_beat_busy, o_m_tvalid && !o_m_tuser, !o_s_tready,
        "new beat taken while the current one still has pixels")
    `DMRD_ASSERT_NEXT(a_accept_runs, i_s_tvalid && o_s_tready, r_state == dmrd_pkg::S_RUN,
        "accepted beat did not start the sequencer")

endmodule

// ===== dv/delta_modulation_row_decoder_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the delta-modulation row decoder: bytes in, pixels checked per beat.
module delta_modulation_row_decoder_test;

    localparam int ROW_MAX     = 4096;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [dmrd_pkg::PIX_W-1:0] value;
        logic [dmrd_pkg::COL_W-1:0] col;
        logic                       row_end;
        logic                       byte_end;
    } t_pixel;

    class t_dm_row_tracker;
        logic [dmrd_pkg::STEP_W-1:0]  step;
        logic [dmrd_pkg::WIDTH_W-1:0] width;
        bit                           want_start;
        logic [dmrd_pkg::PIX_W-1:0]   prev;
        int unsigned                  next_col;
        t_pixel                       pixels_due[$];
        int                           errors;

        function new();
            step       = dmrd_pkg::STEP_RST;
            width      = dmrd_pkg::WIDTH_RST;
            want_start = 1'b1;
            prev       = '0;
            next_col   = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic idx, logic [dmrd_pkg::APB_DW-1:0] v);
            if (idx == dmrd_pkg::REG_STEP) begin
                step = v[dmrd_pkg::STEP_W-1:0];
            end else begin
                width = v[dmrd_pkg::WIDTH_W-1:0];
            end
        endfunction

        // add or subtract the step, round half up, clamp to 0..255
        function logic [dmrd_pkg::PIX_W-1:0] step_pixel(bit up);
            int base;
            int acc;
            base = int'(prev) << 4;
            if (up) begin
                acc = base + int'(step) + 8;
            end else if (int'(step) > base) begin
                return '0;
            end else begin
                acc = base - int'(step) + 8;
            end
            acc = acc >> 4;
            return (acc > 255) ? 8'd255 : acc[dmrd_pkg::PIX_W-1:0];
        endfunction

        function void take_byte(logic [7:0] code);
            int unsigned lim;
            t_pixel      p;
            lim = (width < 2) ? 2 : (width > ROW_MAX) ? ROW_MAX : width;
            if (want_start) begin
                prev       = code;
                next_col   = 1;
                want_start = 1'b0;
                p.value    = code;
                p.col      = '0;
                p.row_end  = 1'b0;
                p.byte_end = 1'b1;
                pixels_due.push_back(p);
                return;
            end
            for (int i = 0; i < 8; i++) begin
                p.value    = step_pixel(code[i]);
                p.col      = next_col[dmrd_pkg::COL_W-1:0];
                p.row_end  = (next_col + 1 >= lim);
                p.byte_end = p.row_end || i == 7;
                pixels_due.push_back(p);
                prev = p.value;
                if (p.row_end) begin
                    want_start = 1'b1;
                    next_col   = 0;
                    break;
                end
                next_col++;
            end
        endfunction

        function void match_pixel(t_pixel got);
            t_pixel want;
            if (pixels_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel value %0d col %0d last %b byte_end %b",
                         $time, got.value, got.col, got.row_end, got.byte_end);
                return;
            end
            want = pixels_due.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: pixel mismatch, expected value %0d col %0d last %b byte_end %b",
                         $time, want.value, want.col, want.row_end, want.byte_end);
                $display("%0t:                   got value %0d col %0d last %b byte_end %b",
                         $time, got.value, got.col, got.row_end, got.byte_end);
            end
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_s_tvalid;
    logic                        o_s_tready;
    logic [7:0]                  i_s_tdata;
    logic                        o_m_tvalid;
    logic                        i_m_tready;
    logic [23:0]                 o_m_tdata;
    logic                        o_m_tlast;
    logic                        o_m_tuser;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [dmrd_pkg::APB_AW-1:0] paddr;
    logic [dmrd_pkg::APB_DW-1:0] pwdata;
    logic [dmrd_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_reqs    = 0;

    t_dm_row_tracker bench = new();

    delta_modulation_row_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // pixel side: check each beat, then choose tready for the next edge
    initial begin
        t_pixel got;
        int     hold_left;
        int     hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid === 1'b1 && i_m_tready) begin
                got.value    = o_m_tdata[7:0];
                got.col      = o_m_tdata[19:8];
                got.row_end  = o_m_tlast;
                got.byte_end = o_m_tuser;
                bench.match_pixel(got);
            end
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] code);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= code;
        do @(posedge i_clk); while (!o_s_tready);
        bench.take_byte(code);
    endtask

    // let every pending pixel out before touching the registers
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (bench.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [dmrd_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        bench.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic run_random(input int n_items, input int tx_pct, input int rx_pct,
                              input bit squeeze);
        logic [dmrd_pkg::APB_DW-1:0] stp;
        logic [dmrd_pkg::APB_DW-1:0] wid;
        for (int k = 0; k < n_items; k++) begin
            if (k % 12 == 0) begin
                settle();
                stp = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(80);
                case ($urandom_range(7))
                    0: begin
                        wid = $urandom();
                    end
                    1: begin
                        wid = $urandom_range(3);
                    end
                    default: begin
                        wid = $urandom_range(24, 2);
                    end
                endcase
                apb_write(dmrd_pkg::REG_STEP, stp);
                apb_write(dmrd_pkg::REG_WIDTH, wid);
                tx_idle_pct  = tx_pct;
                rx_stall_pct = rx_pct;
                if (squeeze && k == 0) hold_reqs++;
            end
            send_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        #3_000_000;
        $display("[delta_modulation_row_decoder] ERROR");
        $finish;
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: start pixel 0, clamp at the bottom, climb
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);

        // largest step, width dropped below the current column
        settle();
        apb_write(dmrd_pkg::REG_STEP, 32'd4095);
        apb_write(dmrd_pkg::REG_WIDTH, 32'd5);
        send_byte(8'hAA);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h0F);

        // zero step, width below the minimum
        settle();
        apb_write(dmrd_pkg::REG_STEP, 32'd0);
        apb_write(dmrd_pkg::REG_WIDTH, 32'd0);
        send_byte(8'h7F);
        send_byte(8'h5A);
        send_byte(8'h01);
        send_byte(8'h00);

        // half step: rounding ties; junk above the register widths
        settle();
        apb_write(dmrd_pkg::REG_STEP, 32'hABCD_F008);
        apb_write(dmrd_pkg::REG_WIDTH, 32'hFFFF_E00A);
        send_byte(8'h40);
        send_byte(8'h55);
        send_byte(8'hC3);

        // saturation at the top after rounding
        settle();
        apb_write(dmrd_pkg::REG_STEP, 32'd24);
        apb_write(dmrd_pkg::REG_WIDTH, 32'd1);
        send_byte(8'hFE);
        send_byte(8'h01);

        // widest register value, then cut the row short
        settle();
        apb_write(dmrd_pkg::REG_STEP, 32'd4095);
        apb_write(dmrd_pkg::REG_WIDTH, 32'd8191);
        send_byte(8'h10);
        send_byte(8'hF0);
        send_byte(8'h0F);
        settle();
        apb_write(dmrd_pkg::REG_WIDTH, 32'd3);
        send_byte(8'h33);

        run_random(48, 0, 0, 1'b1);
        run_random(48, 85, 0, 1'b0);
        run_random(48, 0, 85, 1'b0);
        run_random(48, 13, 13, 1'b0);

        settle();
        repeat (20) @(posedge i_clk);
        if (bench.errors == 0 && bench.pending() == 0) begin
            $display("[delta_modulation_row_decoder] OK");
        end else begin
            $display("[delta_modulation_row_decoder] ERROR");
        end
        $finish;
    end
endmodule
